[sv/rotary_encoder_button_events_assert.svh]
// ----------------------------------------------------------------------------
// Rotary encoder button events: assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_EVENTS_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_EVENTS_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define REB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define REB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define REB_ASSERT(lbl, prop, msg)
`define REB_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[sv/reb_pkg.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: package
// Shared types, codes and reset values of the encoder and button decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package reb_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgDataW-1:0] DebounceResetMs  = 16'd500;
  localparam logic [CfgDataW-1:0] LongPressResetMs = 16'd2500;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_IDX_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_LONG_PRESS = 2'd1;

  typedef enum logic [1:0] {
    CMD_EDGE_A = 2'd0,
    CMD_EDGE_B = 2'd1,
    CMD_POLL   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    EV_RIGHT = 2'd0,
    EV_LEFT  = 2'd1,
    EV_SHORT = 2'd2,
    EV_LONG  = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_LEFT  = 2'd2
  } turn_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_AWAIT   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             pin_a;
    logic             pin_b;
    logic             button_down;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [CfgDataW-1:0] debounce_ms;
    logic [CfgDataW-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] event_code;
  } result_t;

  typedef struct packed {
    phase_e phase;
    turn_e  turn;
  } status_t;

endpackage

`default_nettype wire

[sv/reb_in_if.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: input channel
// Valid/ready channel carrying one encoder edge or button poll.
// ----------------------------------------------------------------------------
`default_nettype none

interface reb_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic                     pin_a;
  logic                     pin_b;
  logic                     button_down;
  logic [reb_pkg::TimeW-1:0] now_ms;

  modport source (output valid, output cmd, output pin_a, output pin_b,
                  output button_down, output now_ms, input ready);
  modport sink   (input valid, input cmd, input pin_a, input pin_b,
                  input button_down, input now_ms, output ready);
endinterface

`default_nettype wire

[sv/reb_out_if.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: output channel
// Valid/ready channel carrying one user event code.
// ----------------------------------------------------------------------------
`default_nettype none

interface reb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

[sv/reb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: configuration registers
// Holds the debounce and long-press times written through the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module reb_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [reb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [reb_pkg::CfgDataW-1:0]  cfg_data_i,
  output reb_pkg::cfg_t                      cfg_o
);

  reb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        reb_pkg::CFG_IDX_DEBOUNCE:   cfg_d.debounce_ms   = cfg_data_i;
        reb_pkg::CFG_IDX_LONG_PRESS: cfg_d.long_press_ms = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= reb_pkg::DebounceResetMs;
      cfg_q.long_press_ms <= reb_pkg::LongPressResetMs;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/reb_in_reg.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: input register
// Captures one accepted transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module reb_in_reg (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  reb_in_if.sink      in_if,
  input  wire logic   take_i,
  output logic        valid_o,
  output reb_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  reb_pkg::item_t item_q;
  logic           load;

  // Free when empty or when the held item leaves in this cycle.
  assign in_if.ready = !valid_q || take_i;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.cmd         <= in_if.cmd;
      item_q.pin_a       <= in_if.pin_a;
      item_q.pin_b       <= in_if.pin_b;
      item_q.button_down <= in_if.button_down;
      item_q.now_ms      <= in_if.now_ms;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[sv/reb_core.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: decoder core
// Detent flags, pending turn and button phase, updated once per item.
// ----------------------------------------------------------------------------
`default_nettype none

module reb_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire reb_pkg::cfg_t  cfg_i,
  input  wire reb_pkg::item_t item_i,
  input  wire logic           fire_i,
  output reb_pkg::result_t    res_o,
  output reb_pkg::status_t    status_o
);

  logic                       exp_a_q, exp_a_d;
  logic                       exp_b_q, exp_b_d;
  reb_pkg::turn_e             turn_q, turn_d;
  reb_pkg::phase_e            phase_q, phase_d;
  logic [reb_pkg::TimeW-1:0]  last_q, last_d;

  logic [reb_pkg::TimeW-1:0]  elapsed;
  logic                       deb_ok, long_ok, both_high;
  logic                       is_poll, press_br, release_br, long_br;

  assign elapsed   = item_i.now_ms - last_q;
  assign deb_ok    = elapsed >= {16'd0, cfg_i.debounce_ms};
  assign long_ok   = elapsed >= {16'd0, cfg_i.long_press_ms};
  assign both_high = item_i.pin_a && item_i.pin_b;

  // Poll branches in priority order; a later one applies only if none before does.
  assign is_poll    = fire_i && (item_i.cmd == reb_pkg::CMD_POLL);
  assign press_br   = item_i.button_down && (phase_q == reb_pkg::PH_IDLE);
  assign release_br = !item_i.button_down && (phase_q != reb_pkg::PH_IDLE);
  assign long_br    = item_i.button_down && (phase_q == reb_pkg::PH_PRESSED) && long_ok;

  // Next state.
  always_comb begin
    exp_a_d = exp_a_q;
    exp_b_d = exp_b_q;
    turn_d  = turn_q;
    phase_d = phase_q;
    last_d  = last_q;
    if (fire_i) begin
      case (item_i.cmd)
        reb_pkg::CMD_EDGE_A: begin
          if (both_high && exp_a_q) begin
            turn_d  = reb_pkg::TURN_RIGHT;
            exp_a_d = 1'b0;
            exp_b_d = 1'b0;
          end else if (item_i.pin_a && !item_i.pin_b) begin
            exp_b_d = 1'b1;
          end
        end
        reb_pkg::CMD_EDGE_B: begin
          if (both_high && exp_b_q) begin
            turn_d  = reb_pkg::TURN_LEFT;
            exp_a_d = 1'b0;
            exp_b_d = 1'b0;
          end else if (item_i.pin_b && !item_i.pin_a) begin
            exp_a_d = 1'b1;
          end
        end
        reb_pkg::CMD_POLL: begin
          if (press_br) begin
            if (deb_ok) begin
              phase_d = reb_pkg::PH_PRESSED;
              last_d  = item_i.now_ms;
            end
          end else if (release_br) begin
            phase_d = reb_pkg::PH_IDLE;
            last_d  = item_i.now_ms;
          end else if (long_br) begin
            phase_d = reb_pkg::PH_AWAIT;
          end
          turn_d = reb_pkg::TURN_NONE;
        end
        default: ;
      endcase
    end
  end

  // Result of the current item.
  always_comb begin
    res_o.valid      = 1'b0;
    res_o.event_code = reb_pkg::EV_RIGHT;
    if (is_poll) begin
      if (press_br) begin
        res_o.valid = 1'b0;
      end else if (release_br) begin
        res_o.valid      = (phase_q == reb_pkg::PH_PRESSED);
        res_o.event_code = reb_pkg::EV_SHORT;
      end else if (long_br) begin
        res_o.valid      = 1'b1;
        res_o.event_code = reb_pkg::EV_LONG;
      end else if (turn_q != reb_pkg::TURN_NONE) begin
        res_o.valid      = 1'b1;
        res_o.event_code = (turn_q == reb_pkg::TURN_RIGHT) ? reb_pkg::EV_RIGHT
                                                          : reb_pkg::EV_LEFT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_a_q <= 1'b0;
      exp_b_q <= 1'b0;
      turn_q  <= reb_pkg::TURN_NONE;
      phase_q <= reb_pkg::PH_IDLE;
      last_q  <= '0;
    end else begin
      exp_a_q <= exp_a_d;
      exp_b_q <= exp_b_d;
      turn_q  <= turn_d;
      phase_q <= phase_d;
      last_q  <= last_d;
    end
  end

  assign status_o.phase = phase_q;
  assign status_o.turn  = turn_q;

endmodule

`default_nettype wire

[sv/reb_out_reg.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: output register
// Holds one event until the receiver takes it and reports when it can load.
// ----------------------------------------------------------------------------
`default_nettype none

module reb_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  wire reb_pkg::result_t res_i,
  output logic                  take_o,
  reb_out_if.source             out_if
);

  logic       valid_q, valid_d;
  logic [1:0] code_q;

  // An item is consumed only when the slot is empty or drains in this cycle.
  assign take_o = item_valid_i && (!valid_q || out_if.ready);

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = res_i.valid;
    end else if (out_if.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_i.valid) begin
      code_q <= res_i.event_code;
    end
  end

  assign out_if.valid      = valid_q;
  assign out_if.event_code = code_q;

endmodule

`default_nettype wire

[sv/rotary_encoder_button_events.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: top level
// Turns encoder edges and button polls into turn and press events.
// ----------------------------------------------------------------------------
// Usage:
//   evt_in_i carries one transaction per encoder edge (cmd edge on A or B, with
//   both pin levels) or per button poll (button level and a millisecond time).
//   evt_out_o carries event codes: right turn, left turn, short and long press.
//   Edges never produce an event; a poll produces at most one.
//   The config port writes the debounce time (index 0) and the long-press time
//   (index 1); write only while no transaction is in flight.
// Timing:
//   An accepted transaction is registered in the input register, decoded from
//   there, and its event, if any, is registered in the output register, which
//   drives evt_out_o. One transaction per cycle is sustained unless a stalled
//   receiver holds an event; the single decode stage and the 32-bit
//   elapsed-time subtract and compare set the clock period.
// Reset:
//   Asynchronous, active low. Detent flags, pending turn and button phase clear,
//   the last change time becomes zero, and the times return to 500 and 2500 ms.
// Stalls:
//   A held event waits in the output register; one more transaction waits in
//   the input register, and evt_in_i.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotary_encoder_button_events_assert.svh"

module rotary_encoder_button_events (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [reb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [reb_pkg::CfgDataW-1:0]  cfg_data_i,
  reb_in_if.sink                             evt_in_i,
  reb_out_if.source                          evt_out_o
);

  reb_pkg::cfg_t    cfg;
  reb_pkg::item_t   item;
  reb_pkg::result_t res;
  reb_pkg::status_t status;
  logic             item_valid;
  logic             take;

  // Debounce and long-press times.
  reb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register: one transaction waits here for the decode stage.
  reb_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (evt_in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  // Decoder state updates only when the item actually moves on.
  reb_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item),
    .fire_i   (take),
    .res_o    (res),
    .status_o (status)
  );

  // Output register decides when the decode stage may advance.
  reb_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .res_i        (res),
    .take_o       (take),
    .out_if       (evt_out_o)
  );

  // Only polls produce events.
  `REB_ASSERT(a_event_from_poll, !res.valid || (item.cmd == reb_pkg::CMD_POLL), "event from non-poll")

  // Every processed poll leaves no turn pending.
  `REB_ASSERT_NEXT(a_poll_clears_turn, take && (item.cmd == reb_pkg::CMD_POLL), status.turn == reb_pkg::TURN_NONE, "turn survived a poll")

  // A long press moves the button to awaiting release.
  `REB_ASSERT_NEXT(a_long_to_await, take && res.valid && (res.event_code == reb_pkg::EV_LONG), status.phase == reb_pkg::PH_AWAIT, "long press without await")

  // A poll with the button up always returns the button to idle.
  `REB_ASSERT_NEXT(a_release_idle, take && (item.cmd == reb_pkg::CMD_POLL) && !item.button_down, status.phase == reb_pkg::PH_IDLE, "release left button busy")

endmodule

`default_nettype wire

[dv/rotary_encoder_button_events_test.sv]
// ----------------------------------------------------------------------------
// Rotary encoder button events: testbench
// Drives encoder edges, button polls and register writes into the decoder and
// checks every event code against an in-bench model of the detent flags, the
// pending turn and the debounced, long-press aware button.
// ----------------------------------------------------------------------------

module rotary_encoder_button_events_test;

  timeunit 1ns;
  timeprecision 1ps;

  import reb_pkg::*;

  // The two register indexes past the defined ones must be harmless.
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // The fourth command code is not defined and must be ignored.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // An event passes the input and output registers after its transaction is
  // accepted; this leaves margin.
  localparam int unsigned SETTLE_CYCLES = 8;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;

  // Predicts the event stream of the decoder and checks what comes out.
  class ui_event_book;
    logic [CfgDataW-1:0] debounce_ms;
    logic [CfgDataW-1:0] long_press_ms;
    logic                arm_a;
    logic                arm_b;
    turn_e               turn;
    phase_e              phase;
    logic [TimeW-1:0]    last_change_ms;
    event_e              awaited_events[$];
    int unsigned         errors;

    function new();
      debounce_ms    = DebounceResetMs;
      long_press_ms  = LongPressResetMs;
      arm_a          = 1'b0;
      arm_b          = 1'b0;
      turn           = TURN_NONE;
      phase          = PH_IDLE;
      last_change_ms = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      if (idx == CFG_IDX_DEBOUNCE) begin
        debounce_ms = value;
      end else if (idx == CFG_IDX_LONG_PRESS) begin
        long_press_ms = value;
      end
    endfunction

    // Updates the model with one accepted transaction and queues its event.
    function void note_item(item_t it);
      logic [TimeW-1:0] elapsed;
      elapsed = it.now_ms - last_change_ms;
      case (it.cmd)
        CMD_EDGE_A: begin
          if (it.pin_a && it.pin_b && arm_a) begin
            turn  = TURN_RIGHT;
            arm_a = 1'b0;
            arm_b = 1'b0;
          end else if (it.pin_a && !it.pin_b) begin
            arm_b = 1'b1;
          end
        end
        CMD_EDGE_B: begin
          if (it.pin_a && it.pin_b && arm_b) begin
            turn  = TURN_LEFT;
            arm_a = 1'b0;
            arm_b = 1'b0;
          end else if (it.pin_b && !it.pin_a) begin
            arm_a = 1'b1;
          end
        end
        CMD_POLL: begin
          if (it.button_down && phase == PH_IDLE) begin
            if (elapsed >= debounce_ms) begin
              phase          = PH_PRESSED;
              last_change_ms = it.now_ms;
            end
          end else if (!it.button_down && phase != PH_IDLE) begin
            if (phase == PH_PRESSED) awaited_events.push_back(EV_SHORT);
            phase          = PH_IDLE;
            last_change_ms = it.now_ms;
          end else if (it.button_down && phase == PH_PRESSED && elapsed >= long_press_ms) begin
            phase = PH_AWAIT;
            awaited_events.push_back(EV_LONG);
          end else if (turn != TURN_NONE) begin
            awaited_events.push_back(turn == TURN_RIGHT ? EV_RIGHT : EV_LEFT);
          end
          turn = TURN_NONE;
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what);
      if (errors < 20) $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_event(logic [1:0] code);
      event_e want;
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("event %0d with no event expected", code));
      end else begin
        want = awaited_events.pop_front();
        if (code !== want) begin
          report_mismatch($sformatf("event %0d, expected %s", code, want.name()));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  reb_in_if in_if();
  reb_out_if out_if();

  rotary_encoder_button_events uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .evt_in_i  (in_if),
    .evt_out_o (out_if)
  );

  ui_event_book book = new();

  // When calm is set, neither the sender nor the receiver ever idles.
  bit calm = 1'b0;

  // Counts transactions that the decoder acts on; ignored commands do not count.
  int unsigned items_sent = 0;

  // Millisecond clock of the simulated user for the random part.
  logic [TimeW-1:0] clock_ms = '0;

  int unsigned stall_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls in about one cycle out of five unless things are calm.
  always @(posedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= 20);
  end

  // Monitor: both channels are sampled at the clock edge, so the values seen
  // here are the ones the decoder acted on. Results are checked before the
  // new input is noted, so a stray event can never match a fresh expectation.
  // The watchdog ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) book.check_event(out_if.event_code);
      if (in_if.valid && in_if.ready) begin
        book.note_item(item_t'({in_if.cmd, in_if.pin_a, in_if.pin_b,
                                in_if.button_down, in_if.now_ms}));
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("** rotary_encoder_button_events: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Presents one transaction and returns at the edge where it is accepted.
  // The sender may idle at random first; valid stays high from one
  // transaction into the next when there is no gap.
  task automatic send_item(input logic [1:0] kind, input logic a, input logic b,
                           input logic down, input logic [TimeW-1:0] now);
    while (!calm && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= kind;
    in_if.pin_a       <= a;
    in_if.pin_b       <= b;
    in_if.button_down <= down;
    in_if.now_ms      <= now;
    do @(posedge clk_i); while (!in_if.ready);
    if (kind != CMD_SPARE) items_sent++;
  endtask

  // Edges carry a random button level and timestamp, which must not matter.
  task automatic encoder_edge(input logic [1:0] kind, input logic a, input logic b);
    send_item(kind, a, b, 1'($urandom_range(1)), $urandom);
  endtask

  // Polls carry random pin levels, which must not matter.
  task automatic poll_at(input logic down, input logic [TimeW-1:0] now);
    send_item(CMD_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)), down, now);
  endtask

  // Time steps are scaled to the current settings so that presses, bounces
  // and long holds all occur; now and then the clock jumps anywhere at all.
  function automatic logic [TimeW-1:0] time_step();
    int unsigned span;
    int unsigned roll;
    span = (book.debounce_ms > book.long_press_ms) ? book.debounce_ms : book.long_press_ms;
    span = span + 2;
    roll = $urandom_range(19);
    if (roll < 5) return $urandom_range(3);
    if (roll < 19) return $urandom_range(span);
    return $urandom;
  endfunction

  task automatic poll_after(input logic down);
    clock_ms = clock_ms + time_step();
    poll_at(down, clock_ms);
  endtask

  task automatic noise_edge();
    encoder_edge(2'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // A detent in either direction, sometimes with stray edges mixed in, and
  // usually followed by a poll that should report it.
  task automatic random_turn();
    logic left;
    left = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) noise_edge();
    if (left) begin
      encoder_edge(CMD_EDGE_A, 1'b1, 1'b0);
      if ($urandom_range(5) == 0) noise_edge();
      encoder_edge(CMD_EDGE_B, 1'b1, 1'b1);
    end else begin
      encoder_edge(CMD_EDGE_B, 1'b0, 1'b1);
      if ($urandom_range(5) == 0) noise_edge();
      encoder_edge(CMD_EDGE_A, 1'b1, 1'b1);
    end
    if ($urandom_range(2) != 0) poll_after($urandom_range(3) == 0);
  endtask

  // The button held over a few polls and then let go, with the odd turn.
  task automatic random_press();
    repeat ($urandom_range(1, 6)) begin
      poll_after(1'b1);
      if ($urandom_range(4) == 0) random_turn();
    end
    repeat ($urandom_range(1, 2)) poll_after(1'b0);
  endtask

  // Anything at all, including the undefined command and wild timestamps.
  task automatic random_noise();
    logic [1:0] kind;
    logic [TimeW-1:0] now;
    kind = 2'($urandom_range(3));
    if ($urandom_range(3) == 0) begin
      now = $urandom;
    end else begin
      clock_ms = clock_ms + time_step();
      now = clock_ms;
    end
    send_item(kind, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), now);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop;
    int unsigned roll;
    stop = items_sent + count;
    while (items_sent < stop) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        random_turn();
      end else if (roll < 75) begin
        random_press();
      end else begin
        random_noise();
      end
    end
  endtask

  // Waits until every expected event has arrived, then lets the pipeline run
  // dry, since edges and quiet polls leave no event to wait for.
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (book.awaited_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    book.write_reg(idx, value);
  endtask

  // Writes both times while the decoder is idle; the spare indexes get junk.
  task automatic set_times(input logic [CfgDataW-1:0] debounce,
                           input logic [CfgDataW-1:0] long_press);
    wait_quiet();
    write_reg(CFG_IDX_DEBOUNCE, debounce);
    write_reg(CFG_IDX_SPARE_LO, CfgDataW'($urandom));
    write_reg(CFG_IDX_LONG_PRESS, long_press);
    write_reg(CFG_IDX_SPARE_HI, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Directed part under the reset times of 500 ms and 2500 ms. The last
  // change time starts at zero, so the first press needs now >= 500.
  task automatic directed_part();
    poll_at(1'b1, 32'd100);                        // debounce not met
    poll_at(1'b0, 32'd200);                        // idle poll, nothing pending
    encoder_edge(CMD_EDGE_B, 1'b0, 1'b1);          // arm the detent on A
    encoder_edge(CMD_EDGE_A, 1'b1, 1'b1);          // right turn pending
    poll_at(1'b0, 32'd300);                        // reports the right turn
    encoder_edge(CMD_EDGE_A, 1'b1, 1'b0);          // arm the detent on B
    encoder_edge(CMD_EDGE_B, 1'b1, 1'b1);          // left turn pending
    encoder_edge(CMD_EDGE_A, 1'b0, 1'b0);
    encoder_edge(CMD_EDGE_B, 1'b0, 1'b0);
    poll_at(1'b0, 32'd300);                        // reports the left turn
    poll_at(1'b0, 32'd300);                        // the turn was cleared
    encoder_edge(CMD_EDGE_B, 1'b0, 1'b1);
    encoder_edge(CMD_EDGE_A, 1'b1, 1'b1);
    poll_at(1'b1, 32'd1000);                       // press swallows the turn
    poll_at(1'b1, 32'd1500);                       // held, not yet long
    poll_at(1'b0, 32'd1600);                       // short press
    poll_at(1'b1, 32'd1700);                       // bounce, too soon
    poll_at(1'b1, 32'd2100);                       // press exactly at debounce
    poll_at(1'b1, 32'd4600);                       // long press exactly at limit
    poll_at(1'b1, 32'd9000);                       // still held, reported once
    poll_at(1'b0, 32'd9100);                       // release after long press
    send_item(CMD_SPARE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    encoder_edge(CMD_EDGE_A, 1'b1, 1'b1);          // both high but not armed
    encoder_edge(CMD_EDGE_B, 1'b1, 1'b1);
    poll_at(1'b0, 32'd9200);
    poll_at(1'b1, 32'hFFFF_FF00);                  // press near the top
    poll_at(1'b1, 32'h0000_0A00);                  // long press across the wrap
    poll_at(1'b0, 32'hFFFF_FFFF);
    encoder_edge(CMD_EDGE_A, 1'b1, 1'b0);
    encoder_edge(CMD_EDGE_B, 1'b1, 1'b1);
    poll_at(1'b1, 32'h0000_0300);                  // press wrapped, turn dropped
    poll_at(1'b0, 32'h0000_0400);                  // short press
    encoder_edge(CMD_EDGE_B, 1'b0, 1'b1);
    encoder_edge(CMD_EDGE_A, 1'b1, 1'b1);
    poll_at(1'b1, 32'h0000_0500);                  // bounce swallows the turn
    poll_at(1'b0, 32'h0000_0600);
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.cmd         <= CMD_EDGE_A;
    in_if.pin_a       <= 1'b0;
    in_if.pin_b       <= 1'b0;
    in_if.button_down <= 1'b0;
    in_if.now_ms      <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_IDX_DEBOUNCE;
    cfg_data_i        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_part();

    // Random phases walk through the extremes of both times. One phase runs
    // with no idling at all on either side.
    clock_ms = $urandom;
    random_phase(170);
    set_times(16'd0, 16'd0);
    random_phase(170);
    set_times(16'hFFFF, 16'hFFFF);
    calm = 1'b1;
    random_phase(170);
    calm = 1'b0;
    set_times(16'hFFFF, 16'd0);
    random_phase(170);
    set_times(16'd0, 16'hFFFF);
    random_phase(170);
    set_times(CfgDataW'($urandom_range(1, 300)), CfgDataW'($urandom_range(1, 3000)));
    random_phase(170);

    wait_quiet();
    if (book.errors == 0) begin
      $display("** rotary_encoder_button_events: PASSED **");
    end else begin
      $display("** rotary_encoder_button_events: FAILED **");
    end
    $finish;
  end

endmodule
